[rtl/core/mtmq_pkg.sv]
package mtmq_pkg;

	localparam int COMM_ID_W = 4;
	localparam int RANK_W    = 16;
	localparam int TAG_W     = 31;
	localparam int HANDLE_W  = 16;
	localparam int MASK_W    = 16;
	localparam int STATUS_W  = 3;

	localparam logic [MASK_W-1:0] COMM_MASK_RESET = 16'h0007;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_FIND  = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_STORED       = 3'd0,
		STAT_UNKNOWN_COMM = 3'd1,
		STAT_FULL         = 3'd2,
		STAT_NO_MATCH     = 3'd3,
		STAT_FOUND        = 3'd4
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_PICK = 1'b1
	} state_t;

	// One queued message descriptor.
	typedef struct packed {
		logic [COMM_ID_W-1:0] comm;
		logic [RANK_W-1:0]    source;
		logic [TAG_W-1:0]     tag;
		logic [HANDLE_W-1:0]  handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller commands to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

endpackage

[rtl/core/mtmq_ctrl.sv]
module mtmq_ctrl
	import mtmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_nxt = ST_PICK;
				end
			end
			ST_PICK: begin
				if (cmd.commit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_PICK: begin
				// result register must be free or draining this cycle
				cmd.commit = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not presented after commit");

	a_commit_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_PICK) && in_stall)
		else $error("controller did not hold off input after capture");

endmodule

[rtl/core/mtmq_dp.sv]
module mtmq_dp
	import mtmq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32,
	parameter int COMM_SLOTS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	input  logic                 cfg_wr_en,
	input  logic [MASK_W-1:0]    cfg_wr_data,
	input  logic                 opcode,
	input  logic [COMM_ID_W-1:0] comm_id,
	input  logic [RANK_W-1:0]    source_rank,
	input  logic [TAG_W-1:0]     msg_tag,
	input  logic                 any_source,
	input  logic                 any_tag,
	input  logic [HANDLE_W-1:0]  buffer_handle,
	output logic [STATUS_W-1:0]  status,
	output logic [HANDLE_W-1:0]  found_handle,
	output logic [RANK_W-1:0]    found_source,
	output logic [TAG_W-1:0]     found_tag
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [MASK_W-1:0]      mask_q;
	logic [CW-1:0]          count_q;
	entry_t                 ent_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_vec;
	logic [QUEUE_DEPTH-1:0] match_vec;

	// request stage
	opcode_t                req_op_s1;
	entry_t                 req_ent_s1;
	logic                   req_en_s1;
	logic [QUEUE_DEPTH-1:0] match_s1;

	logic                   comm_en;
	logic                   full;
	logic                   hit;
	logic [QUEUE_DEPTH-1:0] below_hit;
	logic [QUEUE_DEPTH-1:0] first_oh;
	logic [QUEUE_DEPTH-1:0] shift_vec;
	logic [ENTRY_W-1:0]     pick_bits;
	entry_t                 pick;
	logic                   do_store;
	logic                   do_remove;
	status_t                status_nxt;

	assign comm_en = (32'(comm_id) < COMM_SLOTS) && mask_q[comm_id];

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid_vec[i] = count_q > CW'(i);
			match_vec[i] = valid_vec[i] && (ent_q[i].comm == comm_id) &&
				(any_source || (ent_q[i].source == source_rank)) &&
				(any_tag || (ent_q[i].tag == msg_tag));
		end
	end

	// lowest set bit of the match vector is the oldest match
	assign below_hit = (match_s1 - QUEUE_DEPTH'(1)) & ~match_s1;
	assign first_oh  = match_s1 & ~(match_s1 - QUEUE_DEPTH'(1));
	assign shift_vec = ~below_hit;
	assign hit       = |match_s1;
	assign full      = count_q == CW'(QUEUE_DEPTH);

	always_comb begin
		pick_bits = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			pick_bits = pick_bits | (ent_q[i] & {ENTRY_W{first_oh[i]}});
		end
	end
	assign pick = entry_t'(pick_bits);

	assign do_store  = cmd.commit && req_en_s1 && (req_op_s1 == OP_STORE) && !full;
	assign do_remove = cmd.commit && req_en_s1 && (req_op_s1 == OP_FIND) && hit;

	always_comb begin
		if (!req_en_s1) begin
			status_nxt = STAT_UNKNOWN_COMM;
		end else if (req_op_s1 == OP_STORE) begin
			status_nxt = full ? STAT_FULL : STAT_STORED;
		end else begin
			status_nxt = hit ? STAT_FOUND : STAT_NO_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= COMM_MASK_RESET;
			count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				mask_q <= cfg_wr_data;
			end
			if (do_store) begin
				count_q <= count_q + CW'(1);
			end else if (do_remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_s1         <= opcode_t'(opcode);
			req_ent_s1.comm   <= comm_id;
			req_ent_s1.source <= source_rank;
			req_ent_s1.tag    <= msg_tag;
			req_ent_s1.handle <= buffer_handle;
			req_en_s1         <= comm_en;
			match_s1          <= match_vec;
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		entry_t upper;
		if (g == QUEUE_DEPTH - 1) begin : g_top
			assign upper = ent_q[g];
		end else begin : g_mid
			assign upper = ent_q[g + 1];
		end
		always_ff @(posedge clk) begin
			if (do_remove && shift_vec[g]) begin
				ent_q[g] <= upper;
			end else if (do_store && (count_q[IW-1:0] == IW'(g))) begin
				ent_q[g] <= req_ent_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= status_nxt;
			if (do_remove) begin
				found_handle <= pick.handle;
				found_source <= pick.source;
				found_tag    <= pick.tag;
			end else begin
				found_handle <= '0;
				found_source <= '0;
				found_tag    <= '0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

	a_match_in_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ((match_s1 & ~valid_vec) == '0))
		else $error("match outside occupied slots");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_remove |=> count_q == $past(count_q) - CW'(1))
		else $error("fill count not decremented on removal");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_store |=> count_q == $past(count_q) + CW'(1))
		else $error("fill count not incremented on store");

endmodule

[rtl/core/message_tag_match_queue_unit.sv]
// Flow: the request fields and slot compare are registered at the input transfer;
//   the result register loads at the commit in the pick state, and out_valid is
//   registered from that commit. No new request is taken until the commit; the
//   oldest-match pick and compaction follow the transfer in the pick state.
// A stalled result holds the pick cycle until the output register frees up.
// Reset: queue empty, comm_enable_mask = 0x0007, controller idle, no result.
module message_tag_match_queue_unit
	import mtmq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32,
	parameter int COMM_SLOTS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: comm_enable_mask
	input  logic                 cfg_wr_en,
	input  logic [MASK_W-1:0]    cfg_wr_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [COMM_ID_W-1:0] comm_id,
	input  logic [RANK_W-1:0]    source_rank,
	input  logic [TAG_W-1:0]     msg_tag,
	input  logic                 any_source,
	input  logic                 any_tag,
	input  logic [HANDLE_W-1:0]  buffer_handle,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [HANDLE_W-1:0]  found_handle,
	output logic [RANK_W-1:0]    found_source,
	output logic [TAG_W-1:0]     found_tag
);

	// capture: request transfer, latch fields and the parallel match vector
	// commit:  pick oldest match, update the queue, load the result register
	ctrl_cmd_t cmd;

	mtmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Queue is a row of cells kept in arrival order, oldest in cell 0;
	// a removal moves every younger cell down one place.
	mtmq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.COMM_SLOTS  (COMM_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.comm_id       (comm_id),
		.source_rank   (source_rank),
		.msg_tag       (msg_tag),
		.any_source    (any_source),
		.any_tag       (any_tag),
		.buffer_handle (buffer_handle),
		.status        (status),
		.found_handle  (found_handle),
		.found_source  (found_source),
		.found_tag     (found_tag)
	);

	// Only one item in flight: no new request transfer until its result is committed.
	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while previous one in flight");

endmodule
